/* sv/rps_pkg.sv */
`timescale 1ns / 1ps

package rps_pkg;

    // default table depth
    localparam int MAX_ENTRIES_DEF = 2048;

    // fixed field widths
    localparam int WORD_W    = 32;
    localparam int ENTRY_W   = 11;
    localparam int INDEX_W   = 11;
    localparam int COUNT_W   = 12;
    localparam int CMD_W     = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET   = COUNT_W'(2048);
    localparam logic [WORD_W-1:0]  WORD_ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_WORD  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* sv/random_permutation_shuffler.sv */
`timescale 1ns / 1ps
// random permutation shuffler: descending fisher-yates over an on-chip table
// input stream: tuser carries the command (start, random word, read entry),
// tdata carries the random word and the read index; one result word per command
// output stream: flags for accepted swap, finished shuffle, ignored command,
// plus the table entry for a read
// cfg_we/cfg_wdata set the entry count; write it only while the block is idle
// work per command, from input accept to output valid:
//   start       an identity fill sweeps the table one entry a cycle
//   random word the shared bit-serial remainder unit (32 steps) and a limit check;
//               if accepted, two table reads and two writes on the single write port
//   read        one registered table read
//   ignored     goes straight to the output state
// one command is in flight at a time; tready is high only when the sequencer
// is idle, so no command is taken before the last one is done, and a new
// command may be taken while the previous result still waits downstream
// after reset the table holds no permutation, reads return status 1, and the
// entry count is 2048; nothing is lost when the receiver stalls, the
// sequencer just holds its result until the output register frees up

module random_permutation_shuffler
    import rps_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: entry count
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_wdata,
    // command words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // random_word[31:0], read_index[42:32]
    input  logic [CMD_W-1:0]      s_axis_tuser,   // command[1:0]
    // result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // accepted[0], shuffle_done[1],
                                                  // entry_value[12:2], status[13]
);

    localparam int AW = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;  // table address
    localparam int NW = $clog2(MAX_ENTRIES + 1);                      // count / modulus
    localparam int WW = (NW > COUNT_W) ? NW : COUNT_W;                // compare width

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_DIV,
        ST_CHECK,
        ST_RD_B,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_RD_WAIT,
        ST_OUT
    } state_t;

    // control state
    state_t          state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [AW-1:0]   pos_reg, pos_next;
    logic            running_reg, running_next;
    logic            started_reg, started_next;
    logic [NW-1:0]   start_n_reg, start_n_next;
    logic [AW-1:0]   fill_reg, fill_next;
    logic            m_valid_reg, m_valid_next;

    // payload
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [AW-1:0]         j_reg, j_next;
    logic [ENTRY_W-1:0]    tmp_reg, tmp_next;
    logic                  res_acc_reg, res_acc_next;
    logic [ENTRY_W-1:0]    res_val_reg, res_val_next;
    logic                  res_stat_reg, res_stat_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // permutation table
    logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_re, mem_we;
    logic [AW-1:0]      mem_raddr, mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // remainder unit
    logic          div_start;
    logic [NW-1:0] div_mod;
    div_stat_t     div_stat;
    logic [NW-1:0] rem_word, rem_ones;

    // input fields
    cmd_t               in_cmd;
    logic [WORD_W-1:0]  in_word;
    logic [INDEX_W-1:0] in_idx;

    logic [WW-1:0]     count_w;
    logic [NW-1:0]     n_active;
    logic              read_ok;
    logic [WORD_W-1:0] limit;
    logic              out_free;

    assign in_cmd  = cmd_t'(s_axis_tuser);
    assign in_word = s_axis_tdata[WORD_W-1:0];
    assign in_idx  = s_axis_tdata[WORD_W +: INDEX_W];

    // entry count saturated to 2..MAX_ENTRIES
    assign count_w  = WW'(count_reg);
    assign n_active = (count_w < WW'(2))           ? NW'(2) :
                      (count_w > WW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(count_w);

    // entry is readable if inside the current count and filled by the last start
    assign read_ok = started_reg && (WW'(in_idx) < WW'(n_active))
                                 && (WW'(in_idx) < WW'(start_n_reg));

    // rejection limit: all ones minus (all ones mod m)
    assign limit    = WORD_ALL_ONES - WORD_W'(rem_ones);
    assign div_mod  = NW'(pos_reg) + NW'(1);
    assign out_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    rps_divider #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .modulus  (div_mod),
        .word     (in_word),
        .stat     (div_stat),
        .rem_word (rem_word),
        .rem_ones (rem_ones)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        running_next  = running_reg;
        started_next  = started_reg;
        start_n_next  = start_n_reg;
        fill_next     = fill_reg;
        m_valid_next  = m_valid_reg;
        word_next     = word_reg;
        j_next        = j_reg;
        tmp_next      = tmp_reg;
        res_acc_next  = res_acc_reg;
        res_val_next  = res_val_reg;
        res_stat_next = res_stat_reg;
        m_data_next   = m_data_reg;
        mem_re        = 1'b0;
        mem_raddr     = pos_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = rd_data_reg;
        div_start     = 1'b0;

        if (m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    word_next     = in_word;
                    res_acc_next  = 1'b0;
                    res_val_next  = '0;
                    res_stat_next = 1'b0;
                    case (in_cmd)
                        CMD_START:
                        begin
                            start_n_next = n_active;
                            pos_next     = AW'(n_active - NW'(1));
                            running_next = 1'b1;
                            started_next = 1'b1;
                            fill_next    = '0;
                            state_next   = ST_FILL;
                        end
                        CMD_WORD:
                        begin
                            if (running_reg)
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                res_stat_next = 1'b1;
                                state_next    = ST_OUT;
                            end
                        end
                        CMD_READ:
                        begin
                            if (read_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(in_idx);
                                state_next = ST_RD_WAIT;
                            end
                            else
                            begin
                                res_stat_next = 1'b1;
                                state_next    = ST_OUT;
                            end
                        end
                        default:
                        begin
                            res_stat_next = 1'b1;
                            state_next    = ST_OUT;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                // identity load, one entry a cycle up to n-1
                mem_we    = 1'b1;
                mem_waddr = fill_reg;
                mem_wdata = ENTRY_W'(fill_reg);
                if (fill_reg == pos_reg)
                    state_next = ST_OUT;
                else
                    fill_next = fill_reg + AW'(1);
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (word_reg < limit)
                begin
                    j_next     = AW'(rem_word);
                    mem_re     = 1'b1;
                    mem_raddr  = pos_reg;
                    state_next = ST_RD_B;
                end
                else
                    state_next = ST_OUT;
            end
            ST_RD_B:
            begin
                // rd_data_reg holds table[position]
                tmp_next   = rd_data_reg;
                mem_re     = 1'b1;
                mem_raddr  = j_reg;
                state_next = ST_SWAP_A;
            end
            ST_SWAP_A:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = rd_data_reg;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                mem_we       = 1'b1;
                mem_waddr    = j_reg;
                mem_wdata    = tmp_reg;
                pos_next     = pos_reg - AW'(1);
                res_acc_next = 1'b1;
                if (pos_reg == AW'(1))
                    running_next = 1'b0;
                state_next   = ST_OUT;
            end
            ST_RD_WAIT:
            begin
                res_val_next = rd_data_reg;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_DATA_W'({res_stat_reg, res_val_reg,
                                                started_reg && !running_reg, res_acc_reg});
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= COUNT_RESET;
            pos_reg     <= '0;
            running_reg <= 1'b0;
            started_reg <= 1'b0;
            start_n_reg <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_we)
                count_reg <= cfg_wdata;
            pos_reg     <= pos_next;
            running_reg <= running_next;
            started_reg <= started_next;
            start_n_reg <= start_n_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        j_reg        <= j_next;
        tmp_reg      <= tmp_next;
        res_acc_reg  <= res_acc_next;
        res_val_reg  <= res_val_next;
        res_stat_reg <= res_stat_next;
        m_data_reg   <= m_data_next;
    end

    // table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // the remainder unit only runs while a word is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("remainder unit busy outside the divide phase");

    // a running shuffle always has a nonzero position and follows a start
    assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (started_reg && (pos_reg != '0)))
        else $error("running with position zero or without a start");

    // a swap lowers the position by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP_B) |=> (pos_reg == $past(pos_reg) - AW'(1)))
        else $error("position not decremented after swap");

    // a result is only loaded into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("pending result overwritten");

endmodule

/* sv/rps_divider.sv */
`timescale 1ns / 1ps

module rps_divider
    import rps_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]       modulus,
    input  logic [WORD_W-1:0]                      word,
    output div_stat_t                              stat,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]       rem_word,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]       rem_ones
);

    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = $clog2(WORD_W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] step_reg, step_next;
    logic [NW-1:0] mod_reg, mod_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [NW-1:0] rw_reg, rw_next;
    logic [NW-1:0] rf_reg, rf_next;

    logic [NW:0] trial_w, trial_f;

    // two restoring remainder steps in lockstep: the sample and all ones
    always_comb
    begin
        trial_w    = {rw_reg, shift_reg[WORD_W-1]};
        trial_f    = {rf_reg, 1'b1};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        mod_next   = mod_reg;
        shift_next = shift_reg;
        rw_next    = rw_reg;
        rf_next    = rf_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            mod_next   = modulus;
            shift_next = word;
            rw_next    = '0;
            rf_next    = '0;
        end
        else if (busy_reg)
        begin
            rw_next    = (trial_w >= {1'b0, mod_reg}) ? NW'(trial_w - {1'b0, mod_reg})
                                                      : NW'(trial_w);
            rf_next    = (trial_f >= {1'b0, mod_reg}) ? NW'(trial_f - {1'b0, mod_reg})
                                                      : NW'(trial_f);
            shift_next = {shift_reg[WORD_W-2:0], 1'b0};
            step_next  = step_reg + SW'(1);
            if (step_reg == SW'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg   <= mod_next;
        shift_reg <= shift_next;
        rw_reg    <= rw_next;
        rf_reg    <= rf_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem_word  = rw_reg;
    assign rem_ones  = rf_reg;

endmodule
